FILE: hw/rtl/tdps_pkg.sv
// ----------------------------------------------------------------------------
// tdps_pkg
// Types and constants shared by the tick delay priority scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdps_pkg;

  localparam int TaskW  = 5;
  localparam int OpW    = 2;
  localparam int TicksW = 16;
  localparam int WordW  = 32;

  localparam logic [OpW-1:0] OP_TICK   = 2'd0;
  localparam logic [OpW-1:0] OP_DELAY  = 2'd1;
  localparam logic [OpW-1:0] OP_CREATE = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [TicksW-1:0] delay_ticks;
    logic [TaskW-1:0]  task_priority;
  } tdps_in_t;

  typedef struct packed {
    logic [TaskW-1:0] running_task;
    logic             none_ready;
    logic [WordW-1:0] ready_set;
    logic [WordW-1:0] woken_set;
    logic [WordW-1:0] tick_now;
  } tdps_out_t;

  // One priority's slot: both wake tables and its ready bit.
  typedef struct packed {
    logic [WordW-1:0] wake_a;
    logic [WordW-1:0] wake_b;
    logic             ready;
  } tdps_entry_t;

  // Event context seen by the head of the ring during a scan.
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [WordW-1:0] tick;
    logic [WordW-1:0] wake;
    logic             wrap;
    logic             sel;
    logic             target_en;
    logic [TaskW-1:0] target;
  } tdps_ctl_t;

endpackage

FILE: hw/rtl/tdps_stream_if.sv
// ----------------------------------------------------------------------------
// tdps_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tdps_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/tdps_cell.sv
// ----------------------------------------------------------------------------
// tdps_cell
// One slot of the wake ring: holds an entry and passes it on when shifting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdps_cell
  import tdps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        shift,
  input  tdps_entry_t d,
  output tdps_entry_t q
);

  tdps_entry_t slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (shift) begin
      slot <= d;
    end
  end

  assign q = slot;

endmodule

FILE: hw/rtl/tdps_head.sv
// ----------------------------------------------------------------------------
// tdps_head
// Update of the entry leaving the ring head: wake check, sleep or create.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdps_head
  import tdps_pkg::*;
(
  input  tdps_ctl_t        ctl,
  input  logic [TaskW-1:0] idx,
  input  tdps_entry_t      entry_in,
  output tdps_entry_t      entry_out,
  output logic             woken
);

  logic [WordW-1:0] act;
  logic             hit;

  assign act = ctl.sel ? entry_in.wake_b : entry_in.wake_a;
  assign hit = ctl.target_en && (idx == ctl.target);

  always_comb begin
    entry_out = entry_in;
    woken     = 1'b0;
    case (ctl.op)
      OP_TICK: begin
        if ((act != '0) && (ctl.tick >= act)) begin
          woken           = 1'b1;
          entry_out.ready = 1'b1;
          if (ctl.sel) begin
            entry_out.wake_b = '0;
          end else begin
            entry_out.wake_a = '0;
          end
        end
      end
      OP_DELAY: begin
        if (hit) begin
          entry_out.ready = 1'b0;
          // wrapped sum goes to the overflow table
          if (ctl.wrap ^ ctl.sel) begin
            entry_out.wake_b = ctl.wake;
          end else begin
            entry_out.wake_a = ctl.wake;
          end
        end
      end
      OP_CREATE: begin
        if (hit) begin
          entry_out.ready = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/tick_delay_priority_scheduler_core.sv
// ----------------------------------------------------------------------------
// tick_delay_priority_scheduler_core
// Bitmap priority scheduler with tick-based sleeping and two wake tables.
//
// Each event (tick, delay of the current task, create) gives one result.
// The per-priority wake times and ready bits live in a ring of
// NUM_PRIORITIES cells that rotates once per event; a single head unit
// checks or updates one priority per cycle and tracks the highest ready
// priority as the ring turns. An event is accepted, the ring passes
// every cell through the head, then the result register is loaded once free.
// The result register holds a finished transaction until taken; a new
// event is taken only when the previous one has finished its rotation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tick_delay_priority_scheduler_core
  import tdps_pkg::*;
#(
  parameter int NUM_PRIORITIES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  tdps_stream_if.sink          request,
  tdps_stream_if.source        result
);

  localparam int IDX_W = $clog2(NUM_PRIORITIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state;
  logic [IDX_W-1:0] idx;
  logic [TaskW-1:0] idx_ext;
  logic [OpW-1:0]   op_q;
  logic [WordW-1:0] wake_q;
  logic             wrap_q;
  logic             target_en_q;
  logic [TaskW-1:0] target_q;
  logic [WordW-1:0] tick_count;
  logic             sel;
  logic [TaskW-1:0] current_task;
  logic [TaskW-1:0] current_task_next;
  logic [WordW-1:0] woken;
  logic             found;
  logic [TaskW-1:0] best;
  logic             out_valid;
  tdps_out_t        out_payload;

  tdps_in_t         req;
  tdps_ctl_t        ctl;
  tdps_entry_t      cell_q [NUM_PRIORITIES];
  tdps_entry_t      head_out;
  logic             head_woken;
  logic             shift;
  logic             accept;
  logic             last;
  logic             load;
  logic             prio_ok;
  logic [WordW-1:0] ready_vec;

  assign req     = request.payload;
  assign accept  = request.valid && request.ready;
  assign shift   = (state == S_SCAN);
  assign idx_ext = TaskW'(idx);
  assign last    = (idx == IDX_W'(NUM_PRIORITIES - 1));
  assign load    = (state == S_DONE) && (!out_valid || result.ready);
  assign prio_ok = ({27'd0, req.task_priority} < WordW'(NUM_PRIORITIES));

  assign request.ready  = (state == S_IDLE);
  assign result.valid   = out_valid;
  assign result.payload = out_payload;

  always_comb begin
    ctl.op        = op_q;
    ctl.tick      = tick_count;
    ctl.wake      = wake_q;
    ctl.wrap      = wrap_q;
    ctl.sel       = sel;
    ctl.target_en = target_en_q;
    ctl.target    = target_q;
  end

  tdps_head u_head (
    .ctl       (ctl),
    .idx       (idx_ext),
    .entry_in  (cell_q[0]),
    .entry_out (head_out),
    .woken     (head_woken)
  );

  for (genvar g = 0; g < NUM_PRIORITIES; g++) begin : g_ring
    tdps_entry_t d;
    if (g == NUM_PRIORITIES - 1) begin : g_tail
      assign d = head_out;
    end else begin : g_link
      assign d = cell_q[g+1];
    end
    tdps_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d),
      .q     (cell_q[g])
    );
  end

  for (genvar g = 0; g < WordW; g++) begin : g_ready
    if (g < NUM_PRIORITIES) begin : g_used
      assign ready_vec[g] = cell_q[g].ready;
    end else begin : g_unused
      assign ready_vec[g] = 1'b0;
    end
  end

  always_comb begin
    current_task_next = current_task;
    if ((op_q == OP_CREATE) && target_en_q) begin
      current_task_next = target_q;
    end else if (((op_q == OP_TICK) || (op_q == OP_DELAY)) && found) begin
      current_task_next = best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      tick_count   <= '0;
      sel          <= 1'b0;
      current_task <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q  <= req.operation;
            woken <= '0;
            found <= 1'b0;
            best  <= '0;
            idx   <= '0;
            state <= S_SCAN;
            case (req.operation)
              OP_TICK: begin
                tick_count  <= tick_count + 1'b1;
                target_en_q <= 1'b0;
                target_q    <= current_task;
                if (tick_count == '1) begin
                  sel <= ~sel;
                end
              end
              OP_DELAY: begin
                {wrap_q, wake_q} <= {1'b0, tick_count} + {17'd0, req.delay_ticks};
                target_en_q      <= 1'b1;
                target_q         <= current_task;
              end
              OP_CREATE: begin
                target_q    <= req.task_priority;
                target_en_q <= prio_ok;
              end
              default: begin
                target_en_q <= 1'b0;
                target_q    <= current_task;
              end
            endcase
          end
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          if (head_woken) begin
            woken[idx_ext] <= 1'b1;
          end
          if (head_out.ready) begin
            found <= 1'b1;
            best  <= idx_ext;
          end
          if (last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            out_payload.running_task <= current_task_next;
            out_payload.none_ready   <= ~found;
            out_payload.ready_set    <= ready_vec;
            out_payload.woken_set    <= woken;
            out_payload.tick_now     <= tick_count;
            current_task             <= current_task_next;
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN) && (idx == '0))
    else $error("scan did not start after accepted transaction");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside completion");

  a_none_ready_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_payload.none_ready == (out_payload.ready_set == '0)))
    else $error("none_ready disagrees with ready_set");

  a_task_in_range: assert property (@(posedge clk) disable iff (rst)
    ({27'd0, current_task} < WordW'(NUM_PRIORITIES)))
    else $error("current task out of range");

  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.operation == OP_TICK)) |=> (tick_count == $past(tick_count) + 1'b1))
    else $error("tick count did not advance");

endmodule
